/* rtl/core/assert_macros.svh */
// assertion macros for the smooth fading border pad
// no dependencies; empty bodies when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SFBP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SFBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SFBP_ASSERT(lbl, clk, rst_n, prop, msg)
`define SFBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/core/sfbp_pkg.sv */
// types, codes and defaults shared by the border pad files
// no dependencies
package sfbp_pkg;
    localparam int DEF_MAX_ROWS     = 64;
    localparam int DEF_MAX_COLS     = 64;
    localparam int DEF_MAX_PAD_ROWS = 32;
    localparam int DEF_MAX_PAD_COLS = 32;

    typedef struct packed {
        logic       mode;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [6:0] read_row;
        logic [6:0] read_col;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [1:0] status;
    } t_out_item;

    typedef enum logic [2:0] {
        CFG_IMAGE_ROWS, CFG_IMAGE_COLS, CFG_PAD_ROWS, CFG_PAD_COLS,
        CFG_PAD_RED, CFG_PAD_GREEN, CFG_PAD_BLUE
    } t_cfg_idx;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NOT_RDY = 2'd1;
    localparam logic [1:0] STAT_OUTSIDE = 2'd2;

    typedef enum logic [1:0] {PASS_TOP, PASS_BOTTOM, PASS_LEFT, PASS_RIGHT} t_pass;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD_WAIT, ST_PASS, ST_FRD0, ST_FRD1, ST_FRD2, ST_FRD3,
        ST_CH_START, ST_CH_WAIT, ST_FWR
    } t_state;

    typedef struct packed {
        logic       start;
        logic       t3;
        logic [9:0] s;
        logic [7:0] z;
    } t_arith_req;

    typedef struct packed {
        logic       done;
        logic [7:0] q;
    } t_arith_rsp;
endpackage

/* rtl/core/sfbp_frame_mem.sv */
// padded frame store, one write and one registered read port
// no dependencies
module sfbp_frame_mem #(
    parameter int AW = 14,
    parameter int DW = 24
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [0:(1<<AW)-1];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/core/sfbp_arith.sv */
// shared blend unit: one multiplier, bit-serial divide, round to even
// uses sfbp_pkg request and response types
module sfbp_arith
    import sfbp_pkg::*;
#(
    parameter int LEN_W = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_arith_req       i_req,
    input  logic [LEN_W-1:0] i_k,
    input  logic [LEN_W-1:0] i_len,
    output t_arith_rsp       o_rsp
);
    localparam int NUM_W = LEN_W + 11;

    logic             r_busy;
    logic [3:0]       r_step;
    logic             r_t3;
    logic [9:0]       r_s;
    logic [7:0]       r_z;
    logic [LEN_W-1:0] r_k;
    logic [LEN_W-1:0] r_len;
    logic [NUM_W-1:0] r_rem;
    logic [NUM_W-1:0] r_den;
    logic [7:0]       r_q;
    logic             r_done;

    logic [9:0]       w_ma;
    logic [LEN_W-1:0] w_mb;
    logic [NUM_W-1:0] w_prod;
    logic [NUM_W-1:0] w_dsh;
    logic [2:0]       w_sh;
    logic [NUM_W:0]   w_rem2;
    logic             w_up;
    logic [8:0]       w_qr;

    always_comb begin
        w_ma   = (r_step == 4'd0) ? r_s : (r_t3 ? 10'(r_z) * 10'd3 : 10'(r_z) * 10'd2);
        w_mb   = (r_step == 4'd0) ? (r_len - r_k) : r_k;
        w_prod = NUM_W'(w_ma) * NUM_W'(w_mb);
        w_sh   = 3'(4'd9 - r_step);
        w_dsh  = r_den << w_sh;
        w_rem2 = {r_rem, 1'b0};
        w_up   = (w_rem2 > (NUM_W+1)'(r_den)) ||
                 ((w_rem2 == (NUM_W+1)'(r_den)) && r_q[0]);
        w_qr   = 9'(r_q) + 9'(w_up);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 4'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= 4'd0;
            end else if (r_busy) begin
                r_step <= r_step + 4'd1;
                if (r_step == 4'd10) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_t3  <= i_req.t3;
            r_s   <= i_req.s;
            r_z   <= i_req.z;
            r_k   <= i_k;
            r_len <= i_len;
        end else if (r_busy) begin
            case (r_step)
                4'd0: begin
                    r_rem <= w_prod;
                    r_den <= r_t3 ? NUM_W'(r_len) * NUM_W'(3) : NUM_W'(r_len) * NUM_W'(2);
                    r_q   <= 8'd0;
                end
                4'd1: r_rem <= r_rem + w_prod;
                4'd10: r_q <= w_qr[8] ? 8'hff : w_qr[7:0];
                default: begin
                    if (r_rem >= w_dsh) begin
                        r_rem <= r_rem - w_dsh;
                        r_q   <= {r_q[6:0], 1'b1};
                    end else begin
                        r_q   <= {r_q[6:0], 1'b0};
                    end
                end
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_q;
endmodule

/* rtl/core/smooth_fading_border_pad.sv */
// reads: a read result passes the frame store read register and the output register; a load stores at once
// flow: loads back to back while no read result waits; a new read is taken only after the last result is taken
// fill: per border pixel, four frame store read states, three channels through the shared
//   multiply and bit-serial divide unit, and one write; each pass adds a ST_PASS state
// reset: control and configuration take reset values; frame store contents are not cleared
module smooth_fading_border_pad
    import sfbp_pkg::*;
#(
    parameter int MAX_ROWS     = DEF_MAX_ROWS,
    parameter int MAX_COLS     = DEF_MAX_COLS,
    parameter int MAX_PAD_ROWS = DEF_MAX_PAD_ROWS,
    parameter int MAX_PAD_COLS = DEF_MAX_PAD_COLS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_data,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);
`include "assert_macros.svh"
    localparam int FH      = MAX_ROWS + 2 * MAX_PAD_ROWS;
    localparam int FW      = MAX_COLS + 2 * MAX_PAD_COLS;
    localparam int RB      = $clog2(FH);
    localparam int CB      = $clog2(FW);
    localparam int XW0     = $clog2((FH > FW ? FH : FW) + 1) + 1;
    localparam int XW      = XW0 < 8 ? 8 : XW0;
    localparam int MAX_PAD = MAX_PAD_ROWS > MAX_PAD_COLS ? MAX_PAD_ROWS : MAX_PAD_COLS;
    localparam int LEN_W   = $clog2(3 * MAX_PAD + 1);

    logic [6:0]  r_img_rows, r_img_cols;
    logic [5:0]  r_pad_rows, r_pad_cols;
    logic [7:0]  r_pad_r, r_pad_g, r_pad_b;
    logic        r_ready;
    logic [XW-1:0] r_lr, r_lc;
    t_state      r_state, n_state;
    t_pass       r_pass;
    logic [XW-1:0] r_k, r_n;
    logic [1:0]  r_ch;
    logic [23:0] r_pa, r_pb, r_pc, r_res;
    logic [1:0]  r_stat;
    logic        r_corner;
    logic        r_ovalid;
    t_out_item   r_out;

    logic [XW-1:0] w_ir, w_ic, w_pr, w_pc, v;
    logic [XW-1:0] w_p, w_nl, w_src, w_dst, w_line, w_along, w_al, w_row, w_col;
    logic [XW+1:0] w_len3;
    logic [XW-1:0] w_rr, w_rc, w_h, w_w;
    logic        w_vert, w_t3, w_acc, w_n_last, w_k_last, w_load_last;
    logic [RB+CB-1:0] w_faddr, w_raddr, w_waddr;
    logic        w_we;
    logic [23:0] w_wdata, w_rdata, w_pad;
    logic [7:0]  w_ca, w_cb, w_cc, w_cz;
    t_arith_req  w_req;
    t_arith_rsp  w_rsp;

    // clamped geometry
    always_comb begin
        v    = XW'(r_img_rows);
        w_ir = v < XW'(2) ? XW'(2) : (v > XW'(MAX_ROWS) ? XW'(MAX_ROWS) : v);
        v    = XW'(r_img_cols);
        w_ic = v < XW'(2) ? XW'(2) : (v > XW'(MAX_COLS) ? XW'(MAX_COLS) : v);
        v    = XW'(r_pad_rows);
        w_pr = v > XW'(MAX_PAD_ROWS) ? XW'(MAX_PAD_ROWS) : v;
        v    = XW'(r_pad_cols);
        w_pc = v > XW'(MAX_PAD_COLS) ? XW'(MAX_PAD_COLS) : v;
        w_h  = w_ir + (w_pr << 1);
        w_w  = w_ic + (w_pc << 1);
        w_rr = XW'(i_in_data.read_row);
        w_rc = XW'(i_in_data.read_col);
        w_pad = {r_pad_r, r_pad_g, r_pad_b};
    end

    // fill pass geometry
    always_comb begin
        w_vert = (r_pass == PASS_TOP) || (r_pass == PASS_BOTTOM);
        w_p    = w_vert ? w_pr : w_pc;
        w_nl   = w_vert ? w_ic : w_ir;
        w_len3 = (XW+2)'(w_p) * (XW+2)'(3);
        case (r_pass)
            PASS_TOP:    w_src = w_pr - r_k;
            PASS_BOTTOM: w_src = w_pr + w_ir - XW'(1) + r_k;
            PASS_LEFT:   w_src = w_pc - r_k;
            default:     w_src = w_pc + w_ic - XW'(1) + r_k;
        endcase
        w_dst = (r_pass == PASS_TOP || r_pass == PASS_LEFT) ? w_src - XW'(1) : w_src + XW'(1);
        w_along = (w_vert ? w_pc : w_pr) + r_n;
        case (r_state)
            ST_FRD1: w_al = (r_n == '0) ? w_along + XW'(1) : w_along - XW'(1);
            ST_FRD2: w_al = w_along + XW'(1);
            default: w_al = w_along;
        endcase
        w_line   = (r_state == ST_FWR) ? w_dst : w_src;
        w_row    = w_vert ? w_line : w_al;
        w_col    = w_vert ? w_al : w_line;
        w_faddr  = {w_row[RB-1:0], w_col[CB-1:0]};
        w_n_last = (r_n == w_nl - XW'(1));
        w_k_last = (r_k == w_p - XW'(1));
        w_t3     = !(r_n == '0 || w_n_last);
        w_load_last = (r_lr == w_ir - XW'(1)) && (r_lc == w_ic - XW'(1));
    end

    // channel operands
    always_comb begin
        case (r_ch)
            2'd0: begin
                w_ca = r_pa[23:16]; w_cb = r_pb[23:16]; w_cc = r_pc[23:16]; w_cz = r_pad_r;
            end
            2'd1: begin
                w_ca = r_pa[15:8]; w_cb = r_pb[15:8]; w_cc = r_pc[15:8]; w_cz = r_pad_g;
            end
            default: begin
                w_ca = r_pa[7:0]; w_cb = r_pb[7:0]; w_cc = r_pc[7:0]; w_cz = r_pad_b;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    if (i_in_data.mode) n_state = ST_RD_WAIT;
                    else if (!r_ready && w_load_last) n_state = ST_PASS;
                end
            end
            ST_RD_WAIT: n_state = ST_IDLE;
            ST_PASS: begin
                if (w_p != '0) n_state = ST_FRD0;
                else if (r_pass == PASS_RIGHT) n_state = ST_IDLE;
            end
            ST_FRD0: n_state = ST_FRD1;
            ST_FRD1: n_state = ST_FRD2;
            ST_FRD2: n_state = ST_FRD3;
            ST_FRD3: n_state = ST_CH_START;
            ST_CH_START: n_state = ST_CH_WAIT;
            ST_CH_WAIT: begin
                if (w_rsp.done) n_state = (r_ch == 2'd2) ? ST_FWR : ST_CH_START;
            end
            ST_FWR: begin
                if (!w_n_last || !w_k_last) n_state = ST_FRD0;
                else if (r_pass == PASS_RIGHT) n_state = ST_IDLE;
                else n_state = ST_PASS;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_in_stall = !(r_state == ST_IDLE && !r_ovalid);
        w_acc      = i_in_valid && !o_in_stall;
        w_raddr    = (r_state == ST_IDLE) ? {w_rr[RB-1:0], w_rc[CB-1:0]} : w_faddr;
        w_we       = 1'b0;
        w_waddr    = w_faddr;
        w_wdata    = r_res;
        case (r_state)
            ST_IDLE: begin
                w_we    = w_acc && !i_in_data.mode && !r_ready;
                w_waddr = {RB'(w_pr + r_lr), CB'(w_pc + r_lc)};
                w_wdata = {i_in_data.red_in, i_in_data.green_in, i_in_data.blue_in};
            end
            ST_FWR: w_we = 1'b1;
            default: w_we = 1'b0;
        endcase
        w_req.start = (r_state == ST_CH_START);
        w_req.t3    = w_t3;
        w_req.s     = 10'(w_ca) + 10'(w_cb) + 10'(w_cc);
        w_req.z     = w_cz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_img_rows <= 7'd64;
            r_img_cols <= 7'd64;
            r_pad_rows <= 6'd32;
            r_pad_cols <= 6'd32;
            r_pad_r    <= 8'd0;
            r_pad_g    <= 8'd0;
            r_pad_b    <= 8'd0;
            r_ready    <= 1'b0;
            r_lr       <= '0;
            r_lc       <= '0;
            r_ovalid   <= 1'b0;
            r_pass     <= PASS_TOP;
            r_k        <= '0;
            r_n        <= '0;
            r_ch       <= 2'd0;
        end else begin
            r_state <= n_state;
            if (r_ovalid && !i_out_stall) r_ovalid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (w_acc && !i_in_data.mode && !r_ready) begin
                        if (r_lc == w_ic - XW'(1)) begin
                            r_lc <= '0;
                            r_lr <= r_lr + XW'(1);
                        end else begin
                            r_lc <= r_lc + XW'(1);
                        end
                        r_pass <= PASS_TOP;
                        r_k    <= '0;
                        r_n    <= '0;
                    end
                end
                ST_RD_WAIT: r_ovalid <= 1'b1;
                ST_PASS: begin
                    if (w_p == '0) begin
                        if (r_pass == PASS_RIGHT) r_ready <= 1'b1;
                        else r_pass <= t_pass'(r_pass + 2'd1);
                    end
                end
                ST_FRD3: r_ch <= 2'd0;
                ST_CH_WAIT: begin
                    if (w_rsp.done) r_ch <= r_ch + 2'd1;
                end
                ST_FWR: begin
                    if (!w_n_last) begin
                        r_n <= r_n + XW'(1);
                    end else begin
                        r_n <= '0;
                        if (!w_k_last) begin
                            r_k <= r_k + XW'(1);
                        end else begin
                            r_k <= '0;
                            if (r_pass == PASS_RIGHT) r_ready <= 1'b1;
                            else r_pass <= t_pass'(r_pass + 2'd1);
                        end
                    end
                end
                default: r_ch <= r_ch;
            endcase
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_IMAGE_ROWS: r_img_rows <= i_cfg_data[6:0];
                    CFG_IMAGE_COLS: r_img_cols <= i_cfg_data[6:0];
                    CFG_PAD_ROWS:   r_pad_rows <= i_cfg_data[5:0];
                    CFG_PAD_COLS:   r_pad_cols <= i_cfg_data[5:0];
                    CFG_PAD_RED:    r_pad_r    <= i_cfg_data;
                    CFG_PAD_GREEN:  r_pad_g    <= i_cfg_data;
                    CFG_PAD_BLUE:   r_pad_b    <= i_cfg_data;
                    default:        r_pad_b    <= r_pad_b;
                endcase
                if (i_cfg_idx <= 3'(CFG_PAD_BLUE)) begin
                    r_ready <= 1'b0;
                    r_lr    <= '0;
                    r_lc    <= '0;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (!r_ready) r_stat <= STAT_NOT_RDY;
                else if (w_rr >= w_h || w_rc >= w_w) r_stat <= STAT_OUTSIDE;
                else r_stat <= STAT_OK;
                r_corner <= (w_rr < w_pr || w_rr >= w_pr + w_ir) &&
                            (w_rc < w_pc || w_rc >= w_pc + w_ic);
            end
            ST_RD_WAIT: begin
                if (r_stat != STAT_OK) begin
                    {r_out.red_out, r_out.green_out, r_out.blue_out} <= 24'd0;
                end else if (r_corner) begin
                    {r_out.red_out, r_out.green_out, r_out.blue_out} <= w_pad;
                end else begin
                    {r_out.red_out, r_out.green_out, r_out.blue_out} <= w_rdata;
                end
                r_out.status <= r_stat;
            end
            ST_FRD1: r_pa <= w_rdata;
            ST_FRD2: r_pb <= w_rdata;
            ST_FRD3: r_pc <= w_t3 ? w_rdata : 24'd0;
            ST_CH_WAIT: begin
                if (w_rsp.done) begin
                    case (r_ch)
                        2'd0:    r_res[23:16] <= w_rsp.q;
                        2'd1:    r_res[15:8]  <= w_rsp.q;
                        default: r_res[7:0]   <= w_rsp.q;
                    endcase
                end
            end
            default: r_res <= r_res;
        endcase
    end

    sfbp_frame_mem #(
        .AW(RB + CB),
        .DW(24)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    sfbp_arith #(
        .LEN_W(LEN_W)
    ) u_arith (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .i_k    (LEN_W'(r_k)),
        .i_len  (w_len3[LEN_W-1:0]),
        .o_rsp  (w_rsp)
    );

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    `SFBP_ASSERT(a_out_from_read, i_clk, i_rst_n,
        $rose(r_ovalid) |-> $past(r_state) == ST_RD_WAIT, "result without a read")
    `SFBP_ASSERT(a_done_in_wait, i_clk, i_rst_n,
        w_rsp.done |-> r_state == ST_CH_WAIT, "blend result outside channel wait")
    `SFBP_ASSERT(a_ready_from_fill, i_clk, i_rst_n,
        $rose(r_ready) |-> ($past(r_state) == ST_PASS || $past(r_state) == ST_FWR),
        "frame ready without border fill")
    `SFBP_ASSERT_NEXT(a_last_load_fills, i_clk, i_rst_n,
        r_state == ST_IDLE && w_acc && !i_in_data.mode && !r_ready && w_load_last && !i_cfg_we,
        r_state == ST_PASS, "last load did not start the fill")
endmodule
